// ----- src/rtss_pkg.sv -----
package rtss_pkg;

    // Default conversion width of the ADC.
    localparam int ADC_BITS_DEFAULT = 12;

    // Widths of the register fields and the result fields.
    localparam int GATE_BITS     = 12;
    localparam int TICK_BITS     = 8;
    localparam int PRESSURE_BITS = 13;
    localparam int COORD_BITS    = 16;

    // Register reset values.
    localparam logic [GATE_BITS-1:0] PEN_DOWN_GATE_RESET    = 12'd400;
    localparam logic [GATE_BITS-1:0] PEN_UP_GATE_RESET      = 12'd2000;
    localparam logic [TICK_BITS-1:0] SETTLE_TICKS_RESET     = 8'd2;
    localparam logic [TICK_BITS-1:0] TRANSITION_TICKS_RESET = 8'd20;
    localparam logic [TICK_BITS-1:0] IDLE_TICKS_RESET       = 8'd100;

    // Pressure limits and the pen-up coordinate marker.
    localparam logic [PRESSURE_BITS-1:0] PRESSURE_MIN = 13'd1;
    localparam logic [PRESSURE_BITS-1:0] PRESSURE_MAX = 13'd8191;
    localparam logic [COORD_BITS-1:0]    COORD_PEN_UP = 16'hffff;

    // APB address and data layout.
    localparam int PADDR_BITS = 5;
    localparam int PDATA_BITS = 32;

    // Register indexes, taken from paddr[4:2].
    typedef enum logic [2:0] {
        REG_SCAN_ENABLE      = 3'd0,
        REG_PEN_DOWN_GATE    = 3'd1,
        REG_PEN_UP_GATE      = 3'd2,
        REG_SETTLE_TICKS     = 3'd3,
        REG_TRANSITION_TICKS = 3'd4,
        REG_IDLE_TICKS       = 3'd5
    } reg_index_t;

    // Panel drive codes.
    typedef enum logic [1:0] {
        MUX_PRESS = 2'd0,
        MUX_X     = 2'd1,
        MUX_Y     = 2'd2
    } mux_code_t;

    // Sense line codes.
    localparam logic CH_FIRST  = 1'b0;
    localparam logic CH_SECOND = 1'b1;

    // Configuration handed from the register block to the sequencer.
    typedef struct packed {
        logic                 scan_enable;
        logic [GATE_BITS-1:0] pen_down_gate;
        logic [GATE_BITS-1:0] pen_up_gate;
        logic [TICK_BITS-1:0] settle_ticks;
        logic [TICK_BITS-1:0] transition_ticks;
        logic [TICK_BITS-1:0] idle_ticks;
    } cfg_t;

endpackage

// ----- src/rtss_if.sv -----
// Channel that carries one finished ADC conversion per item.
interface rtss_adc_if #(
    parameter int ADC_BITS = 12
);
    logic                valid;
    logic                ready;
    logic [ADC_BITS-1:0] conv_code;

    modport source (output valid, output conv_code, input ready);
    modport sink (input valid, input conv_code, output ready);
endinterface

// Channel that carries one scan result per item.
interface rtss_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mux_select;
    logic        next_channel;
    logic [7:0]  delay_ticks;
    logic        sample_valid;
    logic [12:0] sample_pressure;
    logic [15:0] pos_x;
    logic [15:0] sample_y;

    modport source (
        output valid, output mux_select, output next_channel, output delay_ticks,
        output sample_valid, output sample_pressure, output pos_x,
        output sample_y, input ready
    );
    modport sink (
        input valid, input mux_select, input next_channel, input delay_ticks,
        input sample_valid, input sample_pressure, input pos_x,
        input sample_y, output ready
    );
endinterface

// ----- src/resistive_touch_scan_sequencer.sv -----
// Path: an accepted conversion item waits in the input register, then the step decode
// loads the result register, which offers the result; a held result stalls the input register.
// Throughput: one item per cycle while the result receiver keeps up; the input register
// takes a new item while a finished result still waits at the output only when it is empty.
// Reset: asynchronous, active low; the state, valid and configuration registers return to
// their reset values, the scan restarts in the recovery step with the pen marked as lifted.
module resistive_touch_scan_sequencer #(
    parameter int ADC_BITS = rtss_pkg::ADC_BITS_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [rtss_pkg::PADDR_BITS-1:0]  paddr,
    input  logic [rtss_pkg::PDATA_BITS-1:0]  pwdata,
    output logic [rtss_pkg::PDATA_BITS-1:0]  prdata,
    output logic                             pready,
    rtss_adc_if.sink                         conversion,
    rtss_res_if.source                       scan_result
);
    import rtss_pkg::*;

    cfg_t cfg;

    // Configuration registers.
    rtss_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Scan sequencer.
    rtss_core #(
        .ADC_BITS (ADC_BITS)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .conversion  (conversion),
        .scan_result (scan_result)
    );

endmodule

// ----- src/rtss_regs.sv -----
module rtss_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [rtss_pkg::PADDR_BITS-1:0]  paddr,
    input  logic [rtss_pkg::PDATA_BITS-1:0]  pwdata,
    output logic [rtss_pkg::PDATA_BITS-1:0]  prdata,
    output logic                             pready,
    output rtss_pkg::cfg_t                   cfg
);
    import rtss_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    reg_index_t reg_index;
    logic       wr_en;

    assign pready    = 1'b1;
    assign reg_index = reg_index_t'(paddr[4:2]);
    assign wr_en     = psel && penable && pwrite && pready;
    assign cfg       = cfg_reg;

    // Write decode: only the low bits of each register are kept.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_index)
                REG_SCAN_ENABLE:      cfg_next.scan_enable      = pwdata[0];
                REG_PEN_DOWN_GATE:    cfg_next.pen_down_gate    = pwdata[GATE_BITS-1:0];
                REG_PEN_UP_GATE:      cfg_next.pen_up_gate      = pwdata[GATE_BITS-1:0];
                REG_SETTLE_TICKS:     cfg_next.settle_ticks     = pwdata[TICK_BITS-1:0];
                REG_TRANSITION_TICKS: cfg_next.transition_ticks = pwdata[TICK_BITS-1:0];
                REG_IDLE_TICKS:       cfg_next.idle_ticks       = pwdata[TICK_BITS-1:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    // Read decode.
    always_comb
    begin
        unique case (reg_index)
            REG_SCAN_ENABLE:      prdata = PDATA_BITS'(cfg_reg.scan_enable);
            REG_PEN_DOWN_GATE:    prdata = PDATA_BITS'(cfg_reg.pen_down_gate);
            REG_PEN_UP_GATE:      prdata = PDATA_BITS'(cfg_reg.pen_up_gate);
            REG_SETTLE_TICKS:     prdata = PDATA_BITS'(cfg_reg.settle_ticks);
            REG_TRANSITION_TICKS: prdata = PDATA_BITS'(cfg_reg.transition_ticks);
            REG_IDLE_TICKS:       prdata = PDATA_BITS'(cfg_reg.idle_ticks);
            default:              prdata = '0;
        endcase
    end

    // Register file.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.scan_enable      <= 1'b0;
            cfg_reg.pen_down_gate    <= PEN_DOWN_GATE_RESET;
            cfg_reg.pen_up_gate      <= PEN_UP_GATE_RESET;
            cfg_reg.settle_ticks     <= SETTLE_TICKS_RESET;
            cfg_reg.transition_ticks <= TRANSITION_TICKS_RESET;
            cfg_reg.idle_ticks       <= IDLE_TICKS_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ----- src/rtss_core.sv -----
module rtss_core #(
    parameter int ADC_BITS = rtss_pkg::ADC_BITS_DEFAULT
) (
    input  logic           clk,
    input  logic           rst_n,
    input  rtss_pkg::cfg_t cfg,
    rtss_adc_if.sink       conversion,
    rtss_res_if.source     scan_result
);
    import rtss_pkg::*;

    // Width that holds gate + reading - reading with a sign bit.
    localparam int WIDE_BITS = ((ADC_BITS > GATE_BITS) ? ADC_BITS : GATE_BITS) + 2;

    typedef enum logic [2:0] {
        STEP_PY      = 3'd0,
        STEP_PX      = 3'd1,
        STEP_X       = 3'd2,
        STEP_Y       = 3'd3,
        STEP_RECOVER = 3'd4
    } step_t;

    // Input stage.
    logic                in_valid_reg;
    logic [ADC_BITS-1:0] adc_reg;

    // Scan state.
    step_t               step_reg;
    step_t               step_next;
    logic [ADC_BITS-1:0] pressure_y_reg;
    logic [ADC_BITS-1:0] pressure_y_next;
    logic [ADC_BITS-1:0] pressure_x_reg;
    logic [ADC_BITS-1:0] pressure_x_next;
    logic [ADC_BITS-1:0] held_x_reg;
    logic [ADC_BITS-1:0] held_x_next;
    logic                pen_lifted_reg;
    logic                pen_lifted_next;

    // Result stage.
    logic                     res_valid_reg;
    mux_code_t                mux_reg;
    mux_code_t                mux_next;
    logic                     channel_reg;
    logic                     channel_next;
    logic [TICK_BITS-1:0]     delay_reg;
    logic [TICK_BITS-1:0]     delay_next;
    logic                     sample_valid_reg;
    logic                     sample_valid_next;
    logic [PRESSURE_BITS-1:0] pressure_reg;
    logic [PRESSURE_BITS-1:0] pressure_next;
    logic [COORD_BITS-1:0]    x_reg;
    logic [COORD_BITS-1:0]    x_next;
    logic [COORD_BITS-1:0]    y_reg;
    logic [COORD_BITS-1:0]    y_next;

    logic                 advance;
    logic                 fire;
    logic [WIDE_BITS-1:0] down_sum;
    logic [WIDE_BITS-1:0] up_sum;
    logic [WIDE_BITS-1:0] py_wide;
    logic [WIDE_BITS-1:0] raw_pressure;
    logic [PRESSURE_BITS-1:0] clamped_pressure;

    // Handshake: the result register frees up when empty or being taken.
    assign advance          = !res_valid_reg || scan_result.ready;
    assign fire             = in_valid_reg && advance;
    assign conversion.ready = !in_valid_reg || advance;

    assign scan_result.valid           = res_valid_reg;
    assign scan_result.mux_select      = mux_reg;
    assign scan_result.next_channel    = channel_reg;
    assign scan_result.delay_ticks     = delay_reg;
    assign scan_result.sample_valid    = sample_valid_reg;
    assign scan_result.sample_pressure = pressure_reg;
    assign scan_result.pos_x           = x_reg;
    assign scan_result.sample_y        = y_reg;

    // Gate sums against the pressure Y reading.
    assign py_wide      = WIDE_BITS'(pressure_y_reg);
    assign down_sum     = WIDE_BITS'(adc_reg) + WIDE_BITS'(cfg.pen_down_gate);
    assign up_sum       = WIDE_BITS'(adc_reg) + WIDE_BITS'(cfg.pen_up_gate);
    assign raw_pressure = WIDE_BITS'(cfg.pen_down_gate) + WIDE_BITS'(pressure_x_reg)
                          - py_wide;

    // Pressure is clamped to the range that a pen-down sample may carry.
    always_comb
    begin
        if (raw_pressure[WIDE_BITS-1] || (raw_pressure == '0))
            clamped_pressure = PRESSURE_MIN;
        else if (raw_pressure > WIDE_BITS'(PRESSURE_MAX))
            clamped_pressure = PRESSURE_MAX;
        else
            clamped_pressure = raw_pressure[PRESSURE_BITS-1:0];
    end

    // Scan step decode for the conversion in the input register.
    always_comb
    begin
        step_next         = step_reg;
        pressure_y_next   = pressure_y_reg;
        pressure_x_next   = pressure_x_reg;
        held_x_next       = held_x_reg;
        pen_lifted_next   = pen_lifted_reg;
        mux_next          = MUX_PRESS;
        channel_next      = CH_FIRST;
        delay_next        = '0;
        sample_valid_next = 1'b0;
        pressure_next     = '0;
        x_next            = '0;
        y_next            = '0;
        unique case (step_reg)
            STEP_PY:
            begin
                pressure_y_next = adc_reg;
                step_next       = STEP_PX;
                channel_next    = CH_SECOND;
            end
            STEP_PX:
            begin
                pressure_x_next = adc_reg;
                step_next       = STEP_PY;
                if (down_sum > py_wide)
                begin
                    step_next  = STEP_X;
                    mux_next   = MUX_X;
                    delay_next = cfg.settle_ticks;
                end
                else if (up_sum < py_wide)
                begin
                    // Clear pen-up reading: one pen-up sample after a touch.
                    pen_lifted_next = 1'b1;
                    delay_next      = cfg.idle_ticks;
                    if (!pen_lifted_reg)
                    begin
                        sample_valid_next = 1'b1;
                        x_next            = COORD_PEN_UP;
                        y_next            = COORD_PEN_UP;
                    end
                end
                else
                begin
                    delay_next = cfg.transition_ticks;
                end
            end
            STEP_X:
            begin
                held_x_next  = adc_reg;
                step_next    = STEP_Y;
                mux_next     = MUX_Y;
                channel_next = CH_SECOND;
                delay_next   = cfg.settle_ticks;
            end
            STEP_Y:
            begin
                pen_lifted_next   = 1'b0;
                step_next         = STEP_PY;
                delay_next        = cfg.settle_ticks;
                sample_valid_next = 1'b1;
                pressure_next     = clamped_pressure;
                x_next            = COORD_BITS'(held_x_reg);
                y_next            = COORD_BITS'(adc_reg);
            end
            default:
            begin
                // Recovery or an unused step code.
                step_next  = STEP_PY;
                delay_next = cfg.idle_ticks;
            end
        endcase
    end

    // State, input register and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            res_valid_reg  <= 1'b0;
            step_reg       <= STEP_RECOVER;
            pressure_y_reg <= '0;
            pressure_x_reg <= '0;
            held_x_reg     <= '0;
            pen_lifted_reg <= 1'b1;
        end
        else
        begin
            if (conversion.ready)
            begin
                in_valid_reg <= conversion.valid;
            end
            if (conversion.ready && conversion.valid)
            begin
                adc_reg <= conversion.conv_code;
            end
            if (advance)
            begin
                // A disabled block consumes the conversion and gives nothing.
                res_valid_reg <= in_valid_reg && cfg.scan_enable;
            end
            if (fire && cfg.scan_enable)
            begin
                step_reg         <= step_next;
                pressure_y_reg   <= pressure_y_next;
                pressure_x_reg   <= pressure_x_next;
                held_x_reg       <= held_x_next;
                pen_lifted_reg   <= pen_lifted_next;
                mux_reg          <= mux_next;
                channel_reg      <= channel_next;
                delay_reg        <= delay_next;
                sample_valid_reg <= sample_valid_next;
                pressure_reg     <= pressure_next;
                x_reg            <= x_next;
                y_reg            <= y_next;
            end
        end
    end

endmodule

// ----- tb/sv/rtss_scan_checker.sv -----
`timescale 1ns / 1ps

// Watches the register port and both channels of the scan sequencer, predicts
// each scan result from the conversion items and compares the results in order.
module rtss_scan_checker
    import rtss_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_BITS-1:0] paddr,
    input  logic [PDATA_BITS-1:0] pwdata,
    input  logic                  pready,
    rtss_adc_if                   conversion,
    rtss_res_if                   scan_result,
    output int                    fail_count,
    output int                    pending_count
);

    typedef enum logic [2:0] {
        STEP_PRESS_Y = 3'd0,
        STEP_PRESS_X = 3'd1,
        STEP_POS_X   = 3'd2,
        STEP_POS_Y   = 3'd3,
        STEP_RECOVER = 3'd4
    } scan_step_t;

    typedef struct packed {
        mux_code_t                mux_select;
        logic                     next_channel;
        logic [TICK_BITS-1:0]     delay_ticks;
        logic                     sample_valid;
        logic [PRESSURE_BITS-1:0] sample_pressure;
        logic [COORD_BITS-1:0]    pos_x;
        logic [COORD_BITS-1:0]    sample_y;
    } scan_result_t;

    // Shadow copy of the registers.
    logic                 enabled;
    logic [GATE_BITS-1:0] down_gate;
    logic [GATE_BITS-1:0] up_gate;
    logic [TICK_BITS-1:0] settle_delay;
    logic [TICK_BITS-1:0] transition_delay;
    logic [TICK_BITS-1:0] idle_delay;

    // Shadow copy of the scan state.
    scan_step_t                  step;
    logic [ADC_BITS_DEFAULT-1:0] press_y;
    logic [ADC_BITS_DEFAULT-1:0] press_x;
    logic [ADC_BITS_DEFAULT-1:0] x_hold;
    logic                        lifted;

    scan_result_t scan_result_q[$];
    int           errors = 0;

    task automatic report_mismatch(input string msg);
        $display("%0t: scan result mismatch: %s", $time, msg);
        errors++;
    endtask

    task automatic check_field(input string field, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
        begin
            report_mismatch($sformatf("%s is 0x%0h, expected 0x%0h", field, got, want));
        end
    endtask

    function automatic scan_result_t make_result(
        input mux_code_t mux, input logic ch, input logic [TICK_BITS-1:0] dly,
        input logic sv, input logic [PRESSURE_BITS-1:0] pr,
        input logic [COORD_BITS-1:0] x, input logic [COORD_BITS-1:0] y);
        scan_result_t r;
        r.mux_select      = mux;
        r.next_channel    = ch;
        r.delay_ticks     = dly;
        r.sample_valid    = sv;
        r.sample_pressure = pr;
        r.pos_x           = x;
        r.sample_y        = y;
        return r;
    endfunction

    // Advances the shadow scan state by one conversion. Returns 0 when the
    // sequencer is disabled and the conversion causes no result.
    function automatic bit next_scan_result(input logic [ADC_BITS_DEFAULT-1:0] adc,
                                            output scan_result_t res);
        int press;
        if (!enabled)
        begin
            return 1'b0;
        end
        case (step)
            STEP_PRESS_Y:
            begin
                press_y = adc;
                step    = STEP_PRESS_X;
                res     = make_result(MUX_PRESS, CH_SECOND, '0, 1'b0, '0, '0, '0);
            end
            STEP_PRESS_X:
            begin
                press_x = adc;
                if (int'(press_x) + int'(down_gate) > int'(press_y))
                begin
                    // Panel is pressed: go on to the position scans.
                    step = STEP_POS_X;
                    res  = make_result(MUX_X, CH_FIRST, settle_delay, 1'b0, '0, '0, '0);
                end
                else if (int'(press_x) + int'(up_gate) < int'(press_y))
                begin
                    // Clear pen-up: one pen-up sample only after a touch.
                    if (lifted)
                    begin
                        res = make_result(MUX_PRESS, CH_FIRST, idle_delay, 1'b0, '0, '0, '0);
                    end
                    else
                    begin
                        res = make_result(MUX_PRESS, CH_FIRST, idle_delay, 1'b1, '0,
                                          COORD_PEN_UP, COORD_PEN_UP);
                    end
                    lifted = 1'b1;
                    step   = STEP_PRESS_Y;
                end
                else
                begin
                    // Between the gates: discard and retry the pressure scan.
                    step = STEP_PRESS_Y;
                    res  = make_result(MUX_PRESS, CH_FIRST, transition_delay, 1'b0,
                                       '0, '0, '0);
                end
            end
            STEP_POS_X:
            begin
                x_hold = adc;
                step   = STEP_POS_Y;
                res    = make_result(MUX_Y, CH_SECOND, settle_delay, 1'b0, '0, '0, '0);
            end
            STEP_POS_Y:
            begin
                // Pressure is clamped so that a full scan never reads as pen-up.
                press = int'(down_gate) + int'(press_x) - int'(press_y);
                if (press < int'(PRESSURE_MIN))
                begin
                    press = int'(PRESSURE_MIN);
                end
                if (press > int'(PRESSURE_MAX))
                begin
                    press = int'(PRESSURE_MAX);
                end
                lifted = 1'b0;
                step   = STEP_PRESS_Y;
                res    = make_result(MUX_PRESS, CH_FIRST, settle_delay, 1'b1,
                                     PRESSURE_BITS'(press), COORD_BITS'(x_hold),
                                     COORD_BITS'(adc));
            end
            default:
            begin
                // Recovery: restart with a pressure scan after the idle delay.
                step = STEP_PRESS_Y;
                res  = make_result(MUX_PRESS, CH_FIRST, idle_delay, 1'b0, '0, '0, '0);
            end
        endcase
        return 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        scan_result_t want;
        scan_result_t predicted;
        if (!rst_n)
        begin
            enabled          = 1'b0;
            down_gate        = PEN_DOWN_GATE_RESET;
            up_gate          = PEN_UP_GATE_RESET;
            settle_delay     = SETTLE_TICKS_RESET;
            transition_delay = TRANSITION_TICKS_RESET;
            idle_delay       = IDLE_TICKS_RESET;
            step             = STEP_RECOVER;
            press_y          = '0;
            press_x          = '0;
            x_hold           = '0;
            lifted           = 1'b1;
            scan_result_q.delete();
            fail_count    <= errors;
            pending_count <= 0;
        end
        else
        begin
            // Compare an accepted result with the oldest prediction.
            if (scan_result.valid && scan_result.ready)
            begin
                if (scan_result_q.size() == 0)
                begin
                    report_mismatch($sformatf("result item with nothing predicted, mux %0d",
                                              scan_result.mux_select));
                end
                else
                begin
                    want = scan_result_q.pop_front();
                    check_field("mux_select", 16'(scan_result.mux_select),
                                16'(want.mux_select));
                    check_field("next_channel", 16'(scan_result.next_channel),
                                16'(want.next_channel));
                    check_field("delay_ticks", 16'(scan_result.delay_ticks),
                                16'(want.delay_ticks));
                    check_field("sample_valid", 16'(scan_result.sample_valid),
                                16'(want.sample_valid));
                    check_field("sample_pressure", 16'(scan_result.sample_pressure),
                                16'(want.sample_pressure));
                    check_field("pos_x", scan_result.pos_x, want.pos_x);
                    check_field("sample_y", scan_result.sample_y, want.sample_y);
                end
            end

            // Register writes keep only the low bits of each register.
            if (psel && penable && pwrite && pready)
            begin
                case (reg_index_t'(paddr[4:2]))
                    REG_SCAN_ENABLE:      enabled          = pwdata[0];
                    REG_PEN_DOWN_GATE:    down_gate        = pwdata[GATE_BITS-1:0];
                    REG_PEN_UP_GATE:      up_gate          = pwdata[GATE_BITS-1:0];
                    REG_SETTLE_TICKS:     settle_delay     = pwdata[TICK_BITS-1:0];
                    REG_TRANSITION_TICKS: transition_delay = pwdata[TICK_BITS-1:0];
                    REG_IDLE_TICKS:       idle_delay       = pwdata[TICK_BITS-1:0];
                    default:              ;
                endcase
            end

            // Predict the result of an accepted conversion item.
            if (conversion.valid && conversion.ready)
            begin
                if (next_scan_result(conversion.conv_code, predicted))
                begin
                    scan_result_q.push_back(predicted);
                end
            end

            fail_count    <= errors;
            pending_count <= scan_result_q.size();
        end
    end

endmodule

// ----- tb/sv/resistive_touch_scan_sequencer_tb.sv -----
`timescale 1ns / 1ps

module resistive_touch_scan_sequencer_tb;
    import rtss_pkg::*;

    localparam int RESET_CYCLES    = 9;
    localparam int DRAIN_CYCLES    = 6;
    localparam int STALL_LIMIT     = 2000;
    localparam int ITEMS_PER_PHASE = 56;
    localparam int ADC_MAX         = 4095;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [PADDR_BITS-1:0] paddr;
    logic [PDATA_BITS-1:0] pwdata;
    logic [PDATA_BITS-1:0] prdata;
    logic                  pready;

    int fail_count;
    int pending_count;
    int send_idle = 27;
    int recv_idle = 62;
    int cur_down = PEN_DOWN_GATE_RESET;
    int cur_up = PEN_UP_GATE_RESET;
    int stall_cycles = 0;

    rtss_adc_if #(.ADC_BITS(ADC_BITS_DEFAULT)) conversion_ch ();
    rtss_res_if result_ch ();

    resistive_touch_scan_sequencer dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .conversion  (conversion_ch),
        .scan_result (result_ch)
    );

    rtss_scan_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .conversion    (conversion_ch),
        .scan_result   (result_ch),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    always #5 clk = ~clk;

    // The result receiver stalls at random.
    always @(posedge clk)
    begin
        result_ch.ready <= ($urandom_range(99, 0) >= recv_idle);
    end

    // Ends the run when nothing has moved for too long.
    always @(posedge clk)
    begin
        if ((conversion_ch.valid && conversion_ch.ready) ||
            (result_ch.valid && result_ch.ready) || (psel && penable))
        begin
            stall_cycles <= 0;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("resistive_touch_scan_sequencer test failed");
            $finish;
        end
    end

    // Offers one conversion item after a random gap and waits for acceptance.
    task automatic send_conversion(input logic [ADC_BITS_DEFAULT-1:0] value);
        if ($urandom_range(99, 0) < send_idle)
        begin
            conversion_ch.valid <= 1'b0;
            do
            begin
                @(posedge clk);
            end
            while ($urandom_range(99, 0) < send_idle);
        end
        conversion_ch.valid     <= 1'b1;
        conversion_ch.conv_code <= value;
        do
        begin
            @(posedge clk);
        end
        while (!conversion_ch.ready);
    endtask

    // Stops sending and waits until every predicted result has been taken.
    task automatic wait_for_results();
        conversion_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Setup and access cycle; bits above the register width are sometimes junk.
    task automatic write_reg(input reg_index_t idx, input logic [31:0] value,
                             input int width);
        logic [31:0] keep_mask;
        logic [31:0] wdata;
        keep_mask = (32'd1 << width) - 32'd1;
        wdata     = value & keep_mask;
        if ($urandom_range(1, 0) == 1)
        begin
            wdata = wdata | ($urandom() & ~keep_mask);
        end
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apply_config(input logic en, input int down, input int up,
                                input int settle, input int trans, input int idle);
        wait_for_results();
        write_reg(REG_SCAN_ENABLE, 32'(en), 1);
        write_reg(REG_PEN_DOWN_GATE, down, GATE_BITS);
        write_reg(REG_PEN_UP_GATE, up, GATE_BITS);
        write_reg(REG_SETTLE_TICKS, settle, TICK_BITS);
        write_reg(REG_TRANSITION_TICKS, trans, TICK_BITS);
        write_reg(REG_IDLE_TICKS, idle, TICK_BITS);
        cur_down = down;
        cur_up   = up;
    endtask

    // Settings for a random phase: reset values, both gate extremes, or random.
    task automatic pick_config(input int kind);
        int down;
        case (kind)
            0: apply_config(1'b1, PEN_DOWN_GATE_RESET, PEN_UP_GATE_RESET,
                            SETTLE_TICKS_RESET, TRANSITION_TICKS_RESET, IDLE_TICKS_RESET);
            1: apply_config(1'b1, 0, ADC_MAX, 255, 255, 255);
            2: apply_config(1'b1, ADC_MAX, 0, 1, 1, 1);
            default:
            begin
                down = $urandom_range(800, 0);
                apply_config(1'b1, down, $urandom_range(ADC_MAX, down),
                             $urandom_range(255, 1), $urandom_range(255, 1),
                             $urandom_range(255, 1));
            end
        endcase
    endtask

    // Position readings lean toward the ends of the ADC range now and then.
    function automatic logic [ADC_BITS_DEFAULT-1:0] pick_coord();
        case ($urandom_range(9, 0))
            0:       return '0;
            1:       return '1;
            default: return ADC_BITS_DEFAULT'($urandom());
        endcase
    endfunction

    // Mostly well-formed scans shaped by the current gates, some noise items.
    task automatic run_scan_items(input int count);
        int sent;
        int pick;
        int hi;
        logic [ADC_BITS_DEFAULT-1:0] px;
        logic [ADC_BITS_DEFAULT-1:0] py;
        sent = 0;
        while (sent < count)
        begin
            pick = $urandom_range(99, 0);
            if (pick < 50)
            begin
                // Pressed pair, then the X and Y readings.
                px = $urandom_range(ADC_MAX, (cur_down == 0) ? 1 : 0);
                hi = int'(px) + cur_down - 1;
                if (hi > ADC_MAX)
                begin
                    hi = ADC_MAX;
                end
                py = $urandom_range(hi, 0);
                send_conversion(py);
                send_conversion(px);
                send_conversion(pick_coord());
                send_conversion(pick_coord());
                sent += 4;
            end
            else if (pick < 70 && cur_up < ADC_MAX)
            begin
                // Clear pen-up pair.
                px = $urandom_range(ADC_MAX - 1 - cur_up, 0);
                py = $urandom_range(ADC_MAX, int'(px) + cur_up + 1);
                send_conversion(py);
                send_conversion(px);
                sent += 2;
            end
            else if (pick < 85 && cur_down <= cur_up)
            begin
                // Pair that falls between the two gates.
                px = $urandom_range(ADC_MAX - cur_down, 0);
                hi = int'(px) + cur_up;
                if (hi > ADC_MAX)
                begin
                    hi = ADC_MAX;
                end
                py = $urandom_range(hi, int'(px) + cur_down);
                send_conversion(py);
                send_conversion(px);
                sent += 2;
            end
            else
            begin
                send_conversion(ADC_BITS_DEFAULT'($urandom()));
                sent += 1;
            end
        end
    endtask

    initial
    begin
        int mode;
        int phase;
        conversion_ch.valid     = 1'b0;
        conversion_ch.conv_code = '0;
        result_ch.ready         = 1'b0;
        psel                    = 1'b0;
        penable                 = 1'b0;
        pwrite                  = 1'b0;
        paddr                   = '0;
        pwdata                  = '0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Disabled after reset: the item is taken but causes no result.
        send_conversion(12'habc);

        // Enable with the reset settings; the first item leaves recovery.
        apply_config(1'b1, PEN_DOWN_GATE_RESET, PEN_UP_GATE_RESET,
                     SETTLE_TICKS_RESET, TRANSITION_TICKS_RESET, IDLE_TICKS_RESET);
        send_conversion(12'h5a5);
        // Pen up while already lifted: no sample.
        send_conversion(12'd4095);
        send_conversion(12'd0);
        // Reading between the gates.
        send_conversion(12'd2000);
        send_conversion(12'd0);
        // Full scan.
        send_conversion(12'd100);
        send_conversion(12'd50);
        send_conversion(12'd0);
        send_conversion(12'd4095);
        // Pen up after a touch: pen-up sample.
        send_conversion(12'd4095);
        send_conversion(12'd0);
        // Full scan at the field extremes, largest pressure.
        send_conversion(12'd0);
        send_conversion(12'd4095);
        send_conversion(12'd4095);
        send_conversion(12'd0);

        // Gate rewritten during a scan drives the pressure below its floor.
        send_conversion(12'd300);
        send_conversion(12'd0);
        wait_for_results();
        write_reg(REG_PEN_DOWN_GATE, 0, GATE_BITS);
        cur_down = 0;
        send_conversion(12'd123);
        send_conversion(12'd456);

        // Delay registers at zero: every next conversion starts at once.
        wait_for_results();
        write_reg(REG_SETTLE_TICKS, 0, TICK_BITS);
        write_reg(REG_TRANSITION_TICKS, 0, TICK_BITS);
        write_reg(REG_IDLE_TICKS, 0, TICK_BITS);
        send_conversion(12'd2000);
        send_conversion(12'd1000);
        send_conversion(12'd5);
        send_conversion(12'd10);
        send_conversion(12'd7);
        send_conversion(12'd8);
        send_conversion(12'd4095);
        send_conversion(12'd0);

        // Random phases under the three idling patterns.
        for (mode = 0; mode < 3; mode++)
        begin
            case (mode)
                0:
                begin
                    send_idle = 27;
                    recv_idle = 62;
                end
                1:
                begin
                    send_idle = 62;
                    recv_idle = 27;
                end
                default:
                begin
                    send_idle = 0;
                    recv_idle = 0;
                end
            endcase
            for (phase = 0; phase < 3; phase++)
            begin
                pick_config((mode * 3 + phase + 3) % 4);
                run_scan_items(ITEMS_PER_PHASE);
                if (mode == 1 && phase == 1)
                begin
                    // A disabled stretch: items are ignored and the state is kept.
                    wait_for_results();
                    write_reg(REG_SCAN_ENABLE, 0, 1);
                    repeat (8) send_conversion(ADC_BITS_DEFAULT'($urandom()));
                end
            end
        end

        wait_for_results();
        if (fail_count == 0 && pending_count == 0)
        begin
            $display("resistive_touch_scan_sequencer test passed");
        end
        else
        begin
            $display("resistive_touch_scan_sequencer test failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
src/rtss_pkg.sv
src/rtss_if.sv
src/rtss_regs.sv
src/rtss_core.sv
src/resistive_touch_scan_sequencer.sv
tb/sv/rtss_scan_checker.sv
tb/sv/resistive_touch_scan_sequencer_tb.sv
